// File: hw/rtl/hsf_pkg.sv
// hampel spike filter shared package
// holds the window length default and width constants
`timescale 1ns / 1ps
package hsf_pkg;
	localparam int unsigned WindowLenDef = 7;
	localparam int unsigned SampleW      = 32;
	localparam int unsigned DevW         = 33;
	localparam int unsigned GainW        = 8;
	localparam int unsigned MinThrW      = 31;
	localparam int unsigned CfgIdxW      = 1;
	localparam int unsigned CfgDataW     = 31;
	localparam logic [CfgIdxW-1:0] RegMadGain = 1'd0;
	localparam logic [CfgIdxW-1:0] RegMinThr  = 1'd1;
	localparam logic [GainW-1:0]   MadGainRst = 8'd48;
	localparam logic [MinThrW-1:0] MinThrRst  = 31'd256;
endpackage

// File: hw/rtl/hsf_window_mem.sv
// sample window memory, one write port and one registered read port
// depends on hsf_pkg
`timescale 1ns / 1ps
module hsf_window_mem #(
	parameter int unsigned WindowLen = hsf_pkg::WindowLenDef,
	parameter int unsigned AddrW     = $clog2(WindowLen)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AddrW-1:0]           waddr,
	input  logic [hsf_pkg::SampleW-1:0] wdata,
	input  logic [AddrW-1:0]           raddr,
	output logic [hsf_pkg::SampleW-1:0] rdata
);
	import hsf_pkg::*;
	logic [SampleW-1:0] mem [WindowLen];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/hampel_spike_filter.sv
// hampel spike filter: result in the cycle after a request while warming up; once the window
// is full, the time taken, plus any output stall, is set by which entry ranks as median and
// which deviation as mad: each median candidate sweeps the window memory, the deviation load
// reads every entry once, and each mad candidate compares against every stored deviation
// next request can be taken in the same cycle its result is taken, one request in flight
// async active-low reset clears write pointer, fill count and control, sets config to defaults
`timescale 1ns / 1ps
module hampel_spike_filter #(
	parameter int unsigned WindowLen = hsf_pkg::WindowLenDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hsf_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [hsf_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [hsf_pkg::SampleW-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [hsf_pkg::SampleW-1:0] filtered,
	output logic                          spike_replaced,
	output logic                          warming_up
);
	import hsf_pkg::*;
	localparam int unsigned AW = $clog2(WindowLen);
	localparam int unsigned CW = $clog2(WindowLen + 1);
	localparam logic [AW-1:0] LastPos = AW'(WindowLen - 1);
	localparam logic [CW-1:0] Full    = CW'(WindowLen);
	localparam logic [CW-1:0] Half    = CW'(WindowLen / 2);
	localparam logic [2:0] StIdle = 3'd0, StMed = 3'd1, StDev = 3'd2, StMad = 3'd3,
		StCmp = 3'd4, StOut = 3'd5;
	localparam logic [1:0] PhFetch = 2'd0, PhScan = 2'd1, PhWait = 2'd2;

	logic [2:0] state_q;
	logic [1:0] phase_q;
	logic [GainW-1:0] gain_q;
	logic [MinThrW-1:0] minthr_q;
	logic [AW-1:0] wpos_q, i_q, j_q, raddr, idx_s1;
	logic [CW-1:0] fill_q, less_q, leq_q;
	logic signed [SampleW-1:0] s_q, cand_q, med_q;
	logic [DevW-1:0] dev_q [WindowLen];
	logic [DevW-1:0] dcand_q, mad_q;
	logic cand_s1, scan_s1, last_s1, first_q;
	logic issue_cand, issue_scan;
	logic [SampleW-1:0] rdata;
	logic mem_we;
	logic accept;
	logic out_fire;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != StIdle) || (out_valid && out_stall);
	assign mem_we = accept;

	hsf_window_mem #(.WindowLen(WindowLen)) u_mem (
		.clk(clk), .we(mem_we), .waddr(wpos_q), .wdata(sample),
		.raddr(raddr), .rdata(rdata)
	);

	// candidate fetch reads entry i, rank and deviation sweeps read entry j
	assign issue_cand = (state_q == StMed) && (phase_q == PhFetch);
	assign issue_scan = ((state_q == StMed) || (state_q == StDev)) && (phase_q == PhScan);
	assign raddr = issue_cand ? i_q : j_q;

	// absolute deviation of a value from the median
	function automatic logic [DevW-1:0] absdev(input logic signed [SampleW-1:0] a,
		input logic signed [SampleW-1:0] b);
		logic signed [DevW-1:0] d;
		d = DevW'(a) - DevW'(b);
		return d[DevW-1] ? DevW'(-d) : DevW'(d);
	endfunction

	logic signed [SampleW-1:0] rs;
	logic [DevW-1:0] rdev, sdev;
	logic [DevW+4:0] lhs;
	logic [DevW+GainW-1:0] rhs;
	assign rs   = rdata;
	assign rdev = dev_q[j_q];
	assign sdev = absdev(s_q, med_q);
	assign lhs  = {sdev, 4'b0};
	assign rhs  = DevW'(mad_q) * (DevW+GainW)'(gain_q);

	assign out_fire = (state_q == StIdle && accept && fill_q < Full) ||
		(state_q == StOut && !(out_valid && out_stall));

	// read data tags: mark what the memory returns in the cycle after the address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_s1 <= 1'b0; scan_s1 <= 1'b0; last_s1 <= 1'b0; idx_s1 <= '0;
		end else begin
			cand_s1 <= issue_cand;
			scan_s1 <= issue_scan;
			last_s1 <= issue_scan && (j_q == LastPos);
			idx_s1  <= j_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == StDev && scan_s1) dev_q[idx_s1] <= absdev(rs, med_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle; phase_q <= PhFetch; wpos_q <= '0; fill_q <= '0;
			gain_q <= MadGainRst; minthr_q <= MinThrRst; out_valid <= 1'b0;
			filtered <= '0; spike_replaced <= 1'b0; warming_up <= 1'b0;
			i_q <= '0; j_q <= '0; first_q <= 1'b0; less_q <= '0; leq_q <= '0;
			s_q <= '0; cand_q <= '0; med_q <= '0; dcand_q <= '0; mad_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					RegMadGain: gain_q   <= cfg_data[GainW-1:0];
					RegMinThr:  minthr_q <= cfg_data[MinThrW-1:0];
					default: ;
				endcase
			end
			if (out_fire) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				StIdle: begin
					if (accept) begin
						s_q <= sample;
						wpos_q <= (wpos_q == LastPos) ? '0 : wpos_q + 1'b1;
						if (fill_q < Full) begin
							fill_q <= fill_q + 1'b1;
							filtered <= sample; spike_replaced <= 1'b0;
							warming_up <= 1'b1;
						end else begin
							state_q <= StMed; phase_q <= PhFetch; i_q <= '0;
						end
					end
				end
				// candidate i is read first, then all j to count ranks
				StMed: begin
					if (phase_q == PhFetch) begin
						phase_q <= PhScan; j_q <= '0;
					end else if (phase_q == PhScan) begin
						if (j_q == LastPos) phase_q <= PhWait;
						else j_q <= j_q + 1'b1;
					end
					if (cand_s1) begin
						cand_q <= rs; less_q <= '0; leq_q <= '0;
					end else if (scan_s1) begin
						if (last_s1) begin
							if (less_q + CW'(rs < cand_q) <= Half &&
								leq_q + CW'(rs <= cand_q) > Half) begin
								med_q <= cand_q; state_q <= StDev; phase_q <= PhScan;
								j_q <= '0;
							end else begin
								i_q <= i_q + 1'b1; phase_q <= PhFetch;
							end
						end else begin
							less_q <= less_q + CW'(rs < cand_q);
							leq_q  <= leq_q + CW'(rs <= cand_q);
						end
					end
				end
				StDev: begin
					if (phase_q == PhScan) begin
						if (j_q == LastPos) phase_q <= PhWait;
						else j_q <= j_q + 1'b1;
					end
					if (last_s1) begin
						state_q <= StMad; i_q <= '0; j_q <= '0; first_q <= 1'b1;
					end
				end
				StMad: begin
					if (first_q) begin
						dcand_q <= dev_q[i_q]; first_q <= 1'b0; less_q <= '0; leq_q <= '0;
						j_q <= '0;
					end else begin
						less_q <= less_q + CW'(rdev < dcand_q);
						leq_q  <= leq_q + CW'(rdev <= dcand_q);
						if (j_q == LastPos) begin
							if (less_q + CW'(rdev < dcand_q) <= Half &&
								leq_q + CW'(rdev <= dcand_q) > Half) begin
								mad_q <= dcand_q; state_q <= StCmp;
							end else begin
								i_q <= i_q + 1'b1; first_q <= 1'b1;
							end
						end else j_q <= j_q + 1'b1;
					end
				end
				StCmp: state_q <= StOut;
				StOut: begin
					if (!(out_valid && out_stall)) begin
						if (sdev > DevW'(minthr_q) && (DevW+GainW)'(lhs) > rhs) begin
							filtered <= med_q; spike_replaced <= 1'b1;
						end else begin
							filtered <= s_q; spike_replaced <= 1'b0;
						end
						warming_up <= 1'b0; state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	a_warm_no_spike: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && warming_up |-> !spike_replaced) else $error("warm spike");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != StIdle |-> in_stall) else $error("busy not stalled");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= Full) else $error("fill overflow");
endmodule

// File: sim/hampel_spike_filter_check.sv
// checker for the hampel spike filter: watches request and result channels,
// predicts results with its own median/mad model, depends on hsf_pkg
`timescale 1ns / 1ps
module hampel_spike_filter_check (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [hsf_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [hsf_pkg::CfgDataW-1:0]        cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic signed [hsf_pkg::SampleW-1:0]  sample,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [hsf_pkg::SampleW-1:0]  filtered,
	input  logic                                spike_replaced,
	input  logic                                warming_up,
	output int                                  fail_count,
	output int                                  pending
);
	import hsf_pkg::*;
	localparam int W = WindowLenDef;
	localparam int ExpDepth = 1024;

	typedef struct packed {
		logic signed [SampleW-1:0] value;
		logic                      replaced;
		logic                      warm;
	} filt_result_t;

	filt_result_t exp_mem [ExpDepth];
	int exp_head, exp_tail;
	logic signed [SampleW-1:0] win [W];
	int wpos, fill;
	logic [GainW-1:0]   gain;
	logic [MinThrW-1:0] min_thr;

	assign pending = exp_tail - exp_head;

	function automatic logic signed [63:0] rank_mid(input logic signed [63:0] v [W]);
		logic signed [63:0] t;
		logic signed [63:0] a [W];
		a = v;
		for (int i = 1; i < W; i++)
			for (int j = i; j > 0 && a[j-1] > a[j]; j--) begin
				t = a[j]; a[j] = a[j-1]; a[j-1] = t;
			end
		return a[W/2];
	endfunction

	function automatic filt_result_t hampel_predict(input logic signed [SampleW-1:0] s);
		filt_result_t r;
		logic signed [63:0] v [W];
		logic signed [63:0] med, mad, dev;
		win[wpos] = s;
		wpos = (wpos + 1 >= W) ? 0 : wpos + 1;
		if (fill < W) begin
			fill++;
			r.value = s; r.replaced = 1'b0; r.warm = 1'b1;
			return r;
		end
		for (int i = 0; i < W; i++) v[i] = win[i];
		med = rank_mid(v);
		for (int i = 0; i < W; i++) begin
			v[i] = v[i] - med;
			if (v[i] < 0) v[i] = -v[i];
		end
		mad = rank_mid(v);
		dev = s - med;
		if (dev < 0) dev = -dev;
		r.replaced = (dev > $signed({33'd0, min_thr})) &&
			(dev * 16 > $signed({56'd0, gain}) * mad);
		r.value = r.replaced ? med[SampleW-1:0] : s;
		r.warm = 1'b0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		filt_result_t got, want;
		if (!arst_n) begin
			wpos = 0; fill = 0;
			gain = MadGainRst; min_thr = MinThrRst;
			exp_head = 0; exp_tail = 0;
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == RegMadGain) gain = cfg_data[GainW-1:0];
				else if (cfg_index == RegMinThr) min_thr = cfg_data[MinThrW-1:0];
			end
			if (out_valid && !out_stall) begin
				got.value = filtered; got.replaced = spike_replaced; got.warm = warming_up;
				if (exp_tail == exp_head) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: %0d %b %b", filtered, spike_replaced,
							warming_up);
				end else begin
					want = exp_mem[exp_head % ExpDepth];
					exp_head++;
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %0d %b %b, got %0d %b %b",
								want.value, want.replaced, want.warm,
								got.value, got.replaced, got.warm);
					end
				end
			end
			if (in_valid && !in_stall) begin
				exp_mem[exp_tail % ExpDepth] = hampel_predict(sample);
				exp_tail++;
			end
		end
	end
endmodule

// File: sim/hampel_spike_filter_test.sv
// testbench top for the hampel spike filter: drives requests and config,
// random stalls; checking is done by hampel_spike_filter_check
`timescale 1ns / 1ps
module hampel_spike_filter_test;
	import hsf_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = RegMadGain;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SampleW-1:0] sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SampleW-1:0] filtered;
	logic spike_replaced, warming_up;
	int fail_count, pending;
	int out_wait = 0;
	logic signed [SampleW-1:0] base;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	hampel_spike_filter dut (.*);
	hampel_spike_filter_check checker_i (.*);

	// after each result is taken, out_stall is randomly raised to hold off the next one until out_wait runs down
	always @(posedge clk) begin
		int w;
		if (out_valid && !out_stall) begin
			w = $urandom_range(0, 3);
			out_wait <= w;
			out_stall <= (w != 0);
		end else if (out_valid && out_wait != 0) begin
			out_wait <= out_wait - 1;
			out_stall <= (out_wait > 1);
		end
	end

	task automatic send_request(input logic signed [SampleW-1:0] s, input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic drain_and_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
		wait_drained();
		repeat (200) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [SampleW-1:0] near_value(input logic signed [SampleW-1:0] b);
		unique case ($urandom_range(0, 9))
			0: return $urandom();
			1: return b + $signed($urandom_range(0, 4000000)) - 2000000;
			2: return {1'b1, 31'd0};
			3: return {1'b0, {31{1'b1}}};
			default: return b + $signed($urandom_range(0, 600)) - 300;
		endcase
	endfunction

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, warm-up edge, spikes at reset gains
		send_request({1'b1, 31'd0}, 0);
		send_request({1'b0, {31{1'b1}}}, 0);
		send_request(32'sd0, 1);
		send_request(-32'sd1, 1);
		send_request(32'sd100, 0);
		send_request(32'sd200, 0);
		send_request(32'sd300, 0);
		send_request(32'sd100, 0);
		send_request(32'sd100000, 1);
		send_request({1'b1, 31'd0}, 1);
		send_request({1'b0, {31{1'b1}}}, 1);
		for (int i = 0; i < 6; i++) send_request(32'sd1000, 0);
		send_request(32'sd1256, 0);  // distance equal to min threshold, kept
		send_request(32'sd1257, 0);
		drain_and_write(RegMadGain, '0);
		drain_and_write(RegMinThr, '0);
		send_request(32'sd1001, 0);
		send_request(32'sd1000, 0);
		drain_and_write(RegMadGain, 31'h7FFF_FF00 | 31'd255);
		drain_and_write(RegMinThr, {CfgDataW{1'b1}});
		send_request(32'sd5, 0);
		send_request({1'b1, 31'd0}, 0);
		for (int p = 0; p < 6; p++) begin
			drain_and_write(RegMadGain, CfgDataW'($urandom_range(0, 255)));
			drain_and_write(RegMinThr, (p == 5) ? 31'd256 : CfgDataW'($urandom_range(0, 5000)));
			base = $urandom();
			for (int i = 0; i < 90; i++) begin
				if ($urandom_range(0, 50) == 0) base = $urandom();
				send_request(near_value(base), $urandom_range(0, 3) != 0);
				if (p == 2 && i == 40) wait_drained();
			end
		end
		wait_drained();
		repeat (200) @(posedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule

// File: files.f
hw/rtl/hsf_pkg.sv
hw/rtl/hsf_window_mem.sv
hw/rtl/hampel_spike_filter.sv
sim/hampel_spike_filter_check.sv
sim/hampel_spike_filter_test.sv
